/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge, muted while reset is high
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/ibrl_pkg.sv */
// ---------------------------------------------------------------------------
// ibrl_pkg
// Word types and fixed widths for the band row limit block.
// ---------------------------------------------------------------------------
package ibrl_pkg;

   localparam int COL_W  = 12;
   localparam int LEN_W  = 13;
   localparam int ROW_W  = 12;
   localparam int RATE_W = 16;
   localparam int QUO_W  = 13;
   localparam int LIM_W  = 15;

   localparam logic [RATE_W-1:0] RATE_RESET = 16'd32768;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [LEN_W-1:0] len_first;
      logic [LEN_W-1:0] len_second;
   } req_word_type;

   typedef struct packed {
      logic [ROW_W-1:0] lower_row;
      logic [ROW_W-1:0] upper_row;
   } rsp_word_type;

endpackage

/* sv/itakura_band_row_limits.sv */
// ---------------------------------------------------------------------------
// itakura_band_row_limits
// Lowest and highest row of the Itakura band for one DTW column.
// ---------------------------------------------------------------------------
// One request word per cycle while rsp_ready does not hold the pipe, one
// response word per request, in order. Three product stages, fourteen divider
// stages (a range check and then a 13-bit restoring quotient, one bit a stage,
// for the lower and upper line side by side) and the clamping output register.
// Any bubble in the pipe lets a new word in while a response is held.
// The slope rate register resets to one half and is written through csr_.
module itakura_band_row_limits #(
   parameter int MAX_LEN        = 4096,
   parameter int RATE_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ibrl_pkg::RATE_W-1:0]   csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ibrl_pkg::req_word_type        req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ibrl_pkg::rsp_word_type        rsp_word
);
   import ibrl_pkg::*;
   `include "assert_macros.svh"

   localparam int F    = RATE_FRAC_BITS;
   localparam int NW   = F + 27;
   localparam int DW   = F + 14;
   localparam int SIDW = LEN_W + 1;
   localparam int CAP  = (MAX_LEN - 1 < 4095) ? MAX_LEN - 1 : 4095;

   logic [RATE_W-1:0] slope_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_rate_ff <= RATE_RESET;
      end else if (csr_valid) begin
         slope_rate_ff <= csr_wdata;
      end
   end
   assign csr_ready = 1'b1;

   logic          f_valid, f_ready, f_neg;
   logic [NW-1:0] f_nlo, f_nup;
   logic [DW-1:0] f_dlo, f_dup;
   logic [LEN_W-1:0] f_n2;

   ibrl_front #(.FRAC_BITS(F)) u_front (
      .clock      (clock),
      .reset      (reset),
      .rate_reg   (slope_rate_ff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_word    (req_word),
      .out_valid  (f_valid),
      .out_ready  (f_ready),
      .num_lo     (f_nlo),
      .den_lo     (f_dlo),
      .num_up     (f_nup),
      .den_up     (f_dup),
      .low_neg    (f_neg),
      .len_second (f_n2)
   );

   logic             d_valid, d_ready, d_slo, d_sup;
   logic [QUO_W-1:0] d_qlo, d_qup;
   logic [SIDW-1:0]  d_side;

   ibrl_div #(.NUM_W(NW), .DEN_W(DW), .SIDE_W(SIDW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .num_lo    (f_nlo),
      .den_lo    (f_dlo),
      .num_up    (f_nup),
      .den_up    (f_dup),
      .side_in   ({f_neg, f_n2}),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .quo_lo    (d_qlo),
      .quo_up    (d_qup),
      .sat_lo    (d_slo),
      .sat_up    (d_sup),
      .side_out  (d_side)
   );

   logic signed [LIM_W-1:0] lim, lo, up, cap_s;
   rsp_word_type            rsp_word_in;
   logic                    rsp_valid_ff, en_out;

   always_comb begin
      cap_s = LIM_W'(CAP);
      lim   = $signed(LIM_W'(d_side[LEN_W-1:0])) - LIM_W'(2);
      if (d_side[LEN_W]) begin
         lo = LIM_W'(1);
      end else if (d_slo) begin
         lo = lim;
      end else if (lim < $signed(LIM_W'(d_qlo))) begin
         lo = lim;
      end else begin
         lo = $signed(LIM_W'(d_qlo));
      end
      if (lo < LIM_W'(1)) begin
         lo = LIM_W'(1);
      end
      if (lo > cap_s) begin
         lo = cap_s;
      end
      if (d_sup) begin
         up = lim;
      end else if (lim < $signed(LIM_W'(d_qup) + LIM_W'(1))) begin
         up = lim;
      end else begin
         up = $signed(LIM_W'(d_qup) + LIM_W'(1));
      end
      if (up < LIM_W'(0)) begin
         up = '0;
      end
      if (up > cap_s) begin
         up = cap_s;
      end
      rsp_word_in.lower_row = lo[ROW_W-1:0];
      rsp_word_in.upper_row = up[ROW_W-1:0];
   end

   assign en_out  = !rsp_valid_ff || rsp_ready;
   assign d_ready = en_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= d_valid;
      end
      if (en_out) begin
         rsp_word <= rsp_word_in;
      end
   end
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_RST(a_rows_capped, clock, reset,
      rsp_valid |-> (rsp_word.lower_row <= ROW_W'(CAP) && rsp_word.upper_row <= ROW_W'(CAP)
      && rsp_word.lower_row != '0), "row out of range")
   `ASSERT_RST(a_stall_cause, clock, reset,
      !req_ready |-> (rsp_valid && !rsp_ready), "input stalled with room in pipe")
   `ASSERT_ALL(a_reset_empty, clock,
      $past(reset) |-> !rsp_valid, "response valid right after reset")

endmodule

/* sv/ibrl_front.sv */
// ---------------------------------------------------------------------------
// ibrl_front
// Three stage product pipeline: line products, region test, and selection
// of dividend and divisor for the lower and upper lines.
// ---------------------------------------------------------------------------
module ibrl_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ibrl_pkg::RATE_W-1:0]  rate_reg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  ibrl_pkg::req_word_type       in_word,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [FRAC_BITS+26:0]        num_lo,
   output logic [FRAC_BITS+13:0]        den_lo,
   output logic [FRAC_BITS+26:0]        num_up,
   output logic [FRAC_BITS+13:0]        den_up,
   output logic                         low_neg,
   output logic [ibrl_pkg::LEN_W-1:0]   len_second
);
   import ibrl_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int SW = (F > RATE_W) ? F : RATE_W;
   localparam int NW = F + 27;
   localparam int DW = F + 14;

   logic en1, en2, en3;

   // stage 1
   logic [SW-1:0]    rate_ext;
   logic [F-1:0]     rate;
   logic [LEN_W-1:0] n1_fix;
   logic [F:0]       q;
   logic [F+1:0]     d;

   logic             v1_ff;
   logic [LEN_W-1:0] n1_1_ff, n2_1_ff;
   logic [F+13:0]    qn2_1_ff, qn2_1_in;
   logic [F+12:0]    rn2_1_ff, rn2_1_in;
   logic [F+13:0]    qn1_1_ff, qn1_1_in;
   logic [F+13:0]    cd_1_ff, cd_1_in;
   logic [24:0]      n2c_1_ff, n2c_1_in;
   logic [COL_W-1:0] c_1_ff;

   always_comb begin
      rate_ext = SW'(rate_reg);
      if (rate_ext > ((SW'(1) << F) - SW'(1))) begin
         rate = {F{1'b1}};
      end else begin
         rate = rate_ext[F-1:0];
      end
      n1_fix   = (in_word.len_first == '0) ? LEN_W'(1) : in_word.len_first;
      q        = ((F+1)'(1) << F) - (F+1)'(rate);
      d        = ((F+2)'(1) << (F + 1)) - (F+2)'(rate);
      qn2_1_in = (F+14)'(q) * (F+14)'(in_word.len_second);
      rn2_1_in = (F+13)'(rate) * (F+13)'(in_word.len_second);
      qn1_1_in = (F+14)'(q) * (F+14)'(n1_fix);
      cd_1_in  = (F+14)'(d) * (F+14)'(in_word.column);
      n2c_1_in = 25'(in_word.len_second) * 25'(in_word.column);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= in_valid;
      end
      if (en1) begin
         n1_1_ff  <= n1_fix;
         n2_1_ff  <= in_word.len_second;
         c_1_ff   <= in_word.column;
         qn2_1_ff <= qn2_1_in;
         rn2_1_ff <= rn2_1_in;
         qn1_1_ff <= qn1_1_in;
         cd_1_ff  <= cd_1_in;
         n2c_1_ff <= n2c_1_in;
      end
   end

   // stage 2
   logic             v2_ff;
   logic [F+25:0]    qn2c_2_ff, rn2n1_2_ff;
   logic             reg0_2_ff, reg1_2_ff;
   logic [24:0]      n2c_2_ff;
   logic [LEN_W-1:0] n1_2_ff, n2_2_ff;
   logic [F+13:0]    qn1_2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2) begin
         qn2c_2_ff  <= (F+26)'(qn2_1_ff) * (F+26)'(c_1_ff);
         rn2n1_2_ff <= (F+26)'(rn2_1_ff) * (F+26)'(n1_1_ff);
         reg0_2_ff  <= cd_1_ff <= qn1_1_ff;
         reg1_2_ff  <= cd_1_ff <= ((F+14)'(n1_1_ff) << F);
         n2c_2_ff   <= n2c_1_ff;
         n1_2_ff    <= n1_1_ff;
         n2_2_ff    <= n2_1_ff;
         qn1_2_ff   <= qn1_1_ff;
      end
   end

   // stage 3
   logic [NW-1:0] a_v, b_v, n1r;
   logic [NW-1:0] num_lo_in, num_up_in;
   logic [DW-1:0] den_lo_in, den_up_in;
   logic          low_neg_in;
   logic          v3_ff;

   always_comb begin
      a_v        = NW'(n2c_2_ff) << F;
      b_v        = NW'(rn2n1_2_ff);
      n1r        = NW'(n1_2_ff) << F;
      low_neg_in = 1'b0;
      if (reg1_2_ff) begin
         num_lo_in = NW'(qn2c_2_ff);
         den_lo_in = n1r[DW-1:0];
      end else if (a_v > b_v) begin
         num_lo_in = a_v - b_v;
         den_lo_in = qn1_2_ff;
      end else begin
         num_lo_in  = '0;
         den_lo_in  = qn1_2_ff;
         low_neg_in = 1'b1;
      end
      if (reg0_2_ff) begin
         num_up_in = a_v;
         den_up_in = qn1_2_ff;
      end else begin
         num_up_in = NW'(qn2c_2_ff) + b_v;
         den_up_in = n1r[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
      if (en3) begin
         num_lo     <= num_lo_in;
         den_lo     <= den_lo_in;
         num_up     <= num_up_in;
         den_up     <= den_up_in;
         low_neg    <= low_neg_in;
         len_second <= n2_2_ff;
      end
   end

   assign en3       = !v3_ff || out_ready;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign in_ready  = en1;
   assign out_valid = v3_ff;

endmodule

/* sv/ibrl_div.sv */
// ---------------------------------------------------------------------------
// ibrl_div
// Dual lane restoring divider, one quotient bit per stage, with an entry
// stage that flags quotients too wide for the result.
// ---------------------------------------------------------------------------
module ibrl_div #(
   parameter int NUM_W  = 43,
   parameter int DEN_W  = 30,
   parameter int SIDE_W = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [NUM_W-1:0]              num_lo,
   input  logic [DEN_W-1:0]              den_lo,
   input  logic [NUM_W-1:0]              num_up,
   input  logic [DEN_W-1:0]              den_up,
   input  logic [SIDE_W-1:0]             side_in,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [ibrl_pkg::QUO_W-1:0]    quo_lo,
   output logic [ibrl_pkg::QUO_W-1:0]    quo_up,
   output logic                          sat_lo,
   output logic                          sat_up,
   output logic [SIDE_W-1:0]             side_out
);
   import ibrl_pkg::*;

   localparam int STG = QUO_W + 1;

   logic              v_ff    [STG];
   logic              en      [STG];
   logic [NUM_W-1:0]  rlo_ff  [STG];
   logic [NUM_W-1:0]  rup_ff  [STG];
   logic [DEN_W-1:0]  dlo_ff  [STG];
   logic [DEN_W-1:0]  dup_ff  [STG];
   logic [QUO_W-1:0]  qlo_ff  [STG];
   logic [QUO_W-1:0]  qup_ff  [STG];
   logic              slo_ff  [STG];
   logic              sup_ff  [STG];
   logic [SIDE_W-1:0] side_ff [STG];

   for (genvar s = 0; s < STG; s++) begin : g_stg
      if (s == STG - 1) begin : g_last
         assign en[s] = !v_ff[s] || out_ready;
      end else begin : g_mid
         assign en[s] = !v_ff[s] || en[s+1];
      end

      if (s == 0) begin : g_entry
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[s] <= 1'b0;
            end else if (en[s]) begin
               v_ff[s] <= in_valid;
            end
            if (en[s]) begin
               rlo_ff[s]  <= num_lo;
               rup_ff[s]  <= num_up;
               dlo_ff[s]  <= den_lo;
               dup_ff[s]  <= den_up;
               qlo_ff[s]  <= '0;
               qup_ff[s]  <= '0;
               slo_ff[s]  <= num_lo >= (NUM_W'(den_lo) << QUO_W);
               sup_ff[s]  <= num_up >= (NUM_W'(den_up) << QUO_W);
               side_ff[s] <= side_in;
            end
         end
      end else begin : g_bit
         logic [NUM_W-1:0] tlo, tup;
         logic             blo, bup;

         always_comb begin
            tlo = NUM_W'(dlo_ff[s-1]) << (QUO_W - s);
            tup = NUM_W'(dup_ff[s-1]) << (QUO_W - s);
            blo = rlo_ff[s-1] >= tlo;
            bup = rup_ff[s-1] >= tup;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[s] <= 1'b0;
            end else if (en[s]) begin
               v_ff[s] <= v_ff[s-1];
            end
            if (en[s]) begin
               rlo_ff[s]  <= blo ? rlo_ff[s-1] - tlo : rlo_ff[s-1];
               rup_ff[s]  <= bup ? rup_ff[s-1] - tup : rup_ff[s-1];
               dlo_ff[s]  <= dlo_ff[s-1];
               dup_ff[s]  <= dup_ff[s-1];
               qlo_ff[s]  <= {qlo_ff[s-1][QUO_W-2:0], blo};
               qup_ff[s]  <= {qup_ff[s-1][QUO_W-2:0], bup};
               slo_ff[s]  <= slo_ff[s-1];
               sup_ff[s]  <= sup_ff[s-1];
               side_ff[s] <= side_ff[s-1];
            end
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[STG-1];
   assign quo_lo    = qlo_ff[STG-1];
   assign quo_up    = qup_ff[STG-1];
   assign sat_lo    = slo_ff[STG-1];
   assign sat_up    = sup_ff[STG-1];
   assign side_out  = side_ff[STG-1];

endmodule
